// ===== rtl/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Text cursor glyph renderer package
// Shared constants, command codes and the front-to-back queue entry type.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_COUNT_DEF = 256;
  localparam int COORD_BITS_DEF  = 12;

  localparam int CODE_W   = 8;
  localparam int GROW_W   = 4;
  localparam int BITS_W   = 8;
  localparam int CIN_W    = 12;
  localparam int INDEX_W  = 24;
  localparam int COLOR_W  = 32;
  localparam int CFG_W    = 12;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_WIDTH = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GROW_W-1:0]  LAST_GLYPH_ROW = GROW_W'(GLYPH_ROWS - 1);
  localparam logic [CODE_W-1:0]  NEWLINE_CODE   = 8'd10;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_SETCUR = 2'd2;

  localparam logic [1:0] REG_PIXEL_COLOR  = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd1;
  localparam logic [1:0] REG_LINE_PITCH   = 2'd2;

  localparam logic [COLOR_W-1:0] PIXEL_COLOR_RST  = 32'h00FF_FFFF;
  localparam logic [CFG_W-1:0]   SCREEN_WIDTH_RST = 12'd640;
  localparam logic [CFG_W-1:0]   LINE_PITCH_RST   = 12'd640;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_SETCUR
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BASE,
    BK_ROWS
  } back_state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic              glyph_ok;
    logic [CODE_W-1:0] code;
    logic [GROW_W-1:0] glyph_row;
    logic [BITS_W-1:0] row_bits;
    logic [CIN_W-1:0]  x;
    logic [CIN_W-1:0]  y;
  } queue_entry_t;

endpackage

// ===== rtl/tcgr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcgr_front.sv =====
// ----------------------------------------------------------------------------
// Text cursor glyph renderer front end
// Accepts op transactions, classifies them into commands, drops ops that
// have no effect, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module tcgr_front
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [CODE_W-1:0] char_code_i,
  input  logic [GROW_W-1:0] glyph_row_i,
  input  logic [BITS_W-1:0] row_bits_i,
  input  logic [CIN_W-1:0]  new_cursor_x_i,
  input  logic [CIN_W-1:0]  new_cursor_y_i,
  output queue_entry_t      head_o,
  output logic              head_valid_o,
  input  logic              pop_i
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t      entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  queue_entry_t entry;
  logic         keep;
  logic         push;

  always_comb begin
    entry.cmd       = CMD_PUT;
    entry.glyph_ok  = ({2'b00, char_code_i} < 10'(GLYPH_COUNT));
    entry.code      = char_code_i;
    entry.glyph_row = glyph_row_i;
    entry.row_bits  = row_bits_i;
    entry.x         = new_cursor_x_i;
    entry.y         = new_cursor_y_i;
    keep            = 1'b0;
    case (op_i)
      OP_LOAD: begin
        entry.cmd = CMD_LOAD;
        keep      = entry.glyph_ok;
      end
      OP_PUT: begin
        entry.cmd = (char_code_i == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
        keep      = 1'b1;
      end
      OP_SETCUR: begin
        entry.cmd = CMD_SETCUR;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o   = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push         = in_valid_i && in_ready_o && keep;
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ===== rtl/tcgr_back.sv =====
// ----------------------------------------------------------------------------
// Text cursor glyph renderer back end
// Owns the font RAM and the text cursor, executes queued commands and
// streams sixteen glyph rows per character through a read stage and an
// output register.
// ----------------------------------------------------------------------------
module tcgr_back
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  queue_entry_t       head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  input  logic [COLOR_W-1:0] pixel_color_i,
  input  logic [CFG_W-1:0]   screen_width_i,
  input  logic [CFG_W-1:0]   line_pitch_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [INDEX_W-1:0] pixel_index_o,
  output logic [BITS_W-1:0]  pixel_mask_o,
  output logic [COLOR_W-1:0] write_color_o,
  output logic               last_row_o
);

  localparam int GIDX_W = $clog2(GLYPH_COUNT);
  localparam int DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CMP_W  = (COORD_BITS + 2 > CFG_W) ? COORD_BITS + 2 : CFG_W;

  back_state_e state_q, state_d;

  logic [COORD_BITS-1:0] cursor_col_q, cursor_col_d;
  logic [COORD_BITS-1:0] cursor_row_q, cursor_row_d;
  logic [GROW_W-1:0]     row_q, row_d;
  logic                  s1_valid_q, s1_valid_d;
  logic                  out_valid_q, out_valid_d;

  logic [INDEX_W-1:0] prod_q;
  logic [INDEX_W-1:0] idx_q;
  logic [CODE_W-1:0]  code_q;
  logic               glyph_ok_q;
  logic [INDEX_W-1:0] s1_idx_q;
  logic               s1_last_q;
  logic               s1_ok_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic [BITS_W-1:0]  out_mask_q;
  logic               out_last_q;

  logic                         s1_move;
  logic                         issue;
  logic                         last_issue;
  logic                         advance;
  logic                         newline;
  logic [COORD_BITS:0]          next_x;
  logic [COORD_BITS+1:0]        next_x_end;
  logic [COORD_BITS+CFG_W-1:0]  prod_full;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [BITS_W-1:0]            ram_rdata;

  assign s1_move    = !out_valid_q || out_ready_i;
  assign issue      = (state_q == BK_ROWS) && (!s1_valid_q || s1_move);
  assign last_issue = issue && (row_q == LAST_GLYPH_ROW);
  assign pop_o      = (state_q == BK_IDLE) && head_valid_i;

  assign next_x     = {1'b0, cursor_col_q} + (COORD_BITS + 1)'(GLYPH_WIDTH);
  assign next_x_end = {1'b0, next_x} + (COORD_BITS + 2)'(GLYPH_WIDTH);
  assign prod_full  = cursor_row_q * line_pitch_i;

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    advance      = 1'b0;
    newline      = 1'b0;
    ram_we       = 1'b0;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          case (head_i.cmd)
            CMD_LOAD: begin
              ram_we = 1'b1;
            end
            CMD_PUT: begin
              state_d = BK_BASE;
            end
            CMD_NEWLINE: begin
              advance = 1'b1;
              newline = 1'b1;
            end
            CMD_SETCUR: begin
              cursor_col_d = COORD_BITS'(head_i.x);
              cursor_row_d = COORD_BITS'(head_i.y);
            end
            default: begin
              state_d = BK_IDLE;
            end
          endcase
        end
      end
      BK_BASE: begin
        state_d = BK_ROWS;
        row_d   = '0;
      end
      BK_ROWS: begin
        if (issue) begin
          row_d = row_q + 1'b1;
          if (last_issue) begin
            advance = 1'b1;
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    if (advance) begin
      if (newline || (CMP_W'(next_x_end) > CMP_W'(screen_width_i))) begin
        cursor_col_d = '0;
        cursor_row_d = cursor_row_q + COORD_BITS'(GLYPH_ROWS);
      end else begin
        cursor_col_d = next_x[COORD_BITS-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (issue) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (s1_move && s1_valid_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      row_q        <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      row_q        <= row_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q     <= INDEX_W'(prod_full);
      code_q     <= head_i.code;
      glyph_ok_q <= head_i.glyph_ok;
    end
    if (state_q == BK_BASE) begin
      idx_q <= prod_q + INDEX_W'(cursor_col_q);
    end else if (issue) begin
      idx_q <= idx_q + INDEX_W'(line_pitch_i);
    end
    if (issue) begin
      s1_idx_q  <= idx_q;
      s1_last_q <= (row_q == LAST_GLYPH_ROW);
      s1_ok_q   <= glyph_ok_q;
    end
    if (s1_move && s1_valid_q) begin
      out_idx_q  <= s1_idx_q;
      out_mask_q <= s1_ok_q ? ram_rdata : '0;
      out_last_q <= s1_last_q;
    end
  end

  assign ram_waddr = {GIDX_W'(head_i.code), head_i.glyph_row};
  assign ram_raddr = {GIDX_W'(code_q), row_q};

  tcgr_ram #(
    .WIDTH (BITS_W),
    .DEPTH (DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (head_i.row_bits),
    .re_i    (issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign pixel_mask_o  = out_mask_q;
  assign write_color_o = pixel_color_i;
  assign last_row_o    = out_last_q;

endmodule

// ===== rtl/text_cursor_glyph_renderer_core.sv =====
// ----------------------------------------------------------------------------
// Text cursor glyph renderer core
// 8x16 bitmap font text renderer with font RAM, text cursor and APB
// configuration registers.
// ----------------------------------------------------------------------------
// A printable character occupies the back end as follows: it is taken from the
// command queue while y times the line pitch is formed, the cursor column is
// added, and the single read port of the font RAM delivers its sixteen glyph
// rows, one per read, giving one result transaction per cycle when the output
// is not stalled. Glyph row loads, cursor moves and newlines occupy the back
// end only while taken from the queue; ignored ops never reach it. A two-entry
// queue lets the input take new ops while a character is still being drawn. The
// font RAM is not cleared by reset; render only glyph rows that were loaded.
// Registers: pixel color at 0x0, screen width at 0x4, line pitch at 0x8.
// ----------------------------------------------------------------------------
module text_cursor_glyph_renderer_core
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [CODE_W-1:0]  char_code_i,
  input  logic [GROW_W-1:0]  glyph_row_i,
  input  logic [BITS_W-1:0]  row_bits_i,
  input  logic [CIN_W-1:0]   new_cursor_x_i,
  input  logic [CIN_W-1:0]   new_cursor_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [INDEX_W-1:0] pixel_index_o,
  output logic [BITS_W-1:0]  pixel_mask_o,
  output logic [COLOR_W-1:0] write_color_o,
  output logic               last_row_o
);

  logic [COLOR_W-1:0] pixel_color_q;
  logic [CFG_W-1:0]   screen_width_q;
  logic [CFG_W-1:0]   line_pitch_q;
  logic               cfg_write;
  logic [1:0]         reg_index;

  queue_entry_t head;
  logic         head_valid;
  logic         pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_color_q  <= PIXEL_COLOR_RST;
      screen_width_q <= SCREEN_WIDTH_RST;
      line_pitch_q   <= LINE_PITCH_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_PIXEL_COLOR:  pixel_color_q  <= pwdata;
        REG_SCREEN_WIDTH: screen_width_q <= pwdata[CFG_W-1:0];
        REG_LINE_PITCH:   line_pitch_q   <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PIXEL_COLOR:  prdata = pixel_color_q;
      REG_SCREEN_WIDTH: prdata = PDATA_W'(screen_width_q);
      REG_LINE_PITCH:   prdata = PDATA_W'(line_pitch_q);
      default:          prdata = '0;
    endcase
  end

  tcgr_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .char_code_i    (char_code_i),
    .glyph_row_i    (glyph_row_i),
    .row_bits_i     (row_bits_i),
    .new_cursor_x_i (new_cursor_x_i),
    .new_cursor_y_i (new_cursor_y_i),
    .head_o         (head),
    .head_valid_o   (head_valid),
    .pop_i          (pop)
  );

  tcgr_back #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .pixel_color_i  (pixel_color_q),
    .screen_width_i (screen_width_q),
    .line_pitch_i   (line_pitch_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_index_o  (pixel_index_o),
    .pixel_mask_o   (pixel_mask_o),
    .write_color_o  (write_color_o),
    .last_row_o     (last_row_o)
  );

endmodule
